[hw/rtl/layer_color_blend_macros.svh]
// Assertion macros for the layer blend RTL.
`ifndef LAYER_COLOR_BLEND_MACROS_SVH
`define LAYER_COLOR_BLEND_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define LCB_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("layer_color_blend: same-cycle check failed");

// Next-cycle implication.
`define LCB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("layer_color_blend: next-cycle check failed");

`endif

[hw/rtl/lcb_pkg.sv]
// Types and constants for the layer blend pipeline.
`timescale 1ns / 1ps
`default_nettype none

package lcb_pkg;

  localparam int CH_W     = 16;
  localparam int ALPHA_W  = 13;
  localparam int TGT_W    = 21;
  localparam int OPND_W   = 18;
  localparam int LANES    = 4;
  localparam int ONE_Q12  = 4096;
  localparam int HALF_Q12 = 2048;
  localparam int FRAC_W   = 12;

  typedef enum logic [2:0] {
    MODE_NORMAL   = 3'd0,
    MODE_ADD      = 3'd1,
    MODE_MULTIPLY = 3'd2,
    MODE_SCREEN   = 3'd3,
    MODE_MAX      = 3'd4,
    MODE_MIN      = 3'd5
  } blend_mode_t;

  localparam logic [1:0] REG_BLEND_MODE    = 2'd0;
  localparam logic [1:0] REG_LAYER_OPACITY = 2'd1;
  localparam logic [1:0] REG_MASK_ENABLE   = 2'd2;

  typedef struct packed {
    logic [CH_W-1:0] base_red;
    logic [CH_W-1:0] base_green;
    logic [CH_W-1:0] base_blue;
    logic [CH_W-1:0] base_alpha;
    logic [CH_W-1:0] layer_red;
    logic [CH_W-1:0] layer_green;
    logic [CH_W-1:0] layer_blue;
    logic [CH_W-1:0] layer_alpha;
    logic [CH_W-1:0] mask_value;
  } pixel_in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_alpha;
  } pixel_out_t;

endpackage

`default_nettype wire

[hw/rtl/lcb_alpha.sv]
// Blend weight unit: opacity, times mask when enabled, clamped to 1.0, two stages.
`timescale 1ns / 1ps
`default_nettype none

module lcb_alpha (
  input  wire logic                          clk,
  input  wire logic [lcb_pkg::CH_W-1:0]      opacity,
  input  wire logic                          mask_enable,
  input  wire logic [lcb_pkg::CH_W-1:0]      mask_value,
  output logic      [lcb_pkg::ALPHA_W-1:0]   alpha
);

  localparam int PROD_W = 2 * lcb_pkg::CH_W;

  logic [PROD_W-1:0]            prod;
  logic [PROD_W-1:0]            scaled;
  logic [lcb_pkg::CH_W-1:0]     weight;
  logic [lcb_pkg::ALPHA_W-1:0]  alpha_next;

  always_ff @(posedge clk) begin
    prod <= opacity * mask_value;
  end

  always_comb begin
    scaled = prod >> lcb_pkg::FRAC_W;
    weight = opacity;
    if (mask_enable) begin
      if (scaled > PROD_W'(lcb_pkg::ONE_Q12)) begin
        alpha_next = lcb_pkg::ALPHA_W'(lcb_pkg::ONE_Q12);
      end else begin
        alpha_next = scaled[lcb_pkg::ALPHA_W-1:0];
      end
    end else begin
      if (opacity > lcb_pkg::CH_W'(lcb_pkg::ONE_Q12)) begin
        alpha_next = lcb_pkg::ALPHA_W'(lcb_pkg::ONE_Q12);
      end else begin
        alpha_next = weight[lcb_pkg::ALPHA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    alpha <= alpha_next;
  end

endmodule

`default_nettype wire

[hw/rtl/lcb_lane.sv]
// One color channel lane: target build, lerp toward target, saturate.
`timescale 1ns / 1ps
`default_nettype none

module lcb_lane (
  input  wire logic                          clk,
  input  wire logic [lcb_pkg::CH_W-1:0]      a,
  input  wire logic [lcb_pkg::CH_W-1:0]      b,
  input  wire logic                          is_alpha,
  input  wire lcb_pkg::blend_mode_t          mode,
  input  wire logic [lcb_pkg::ALPHA_W-1:0]   alpha,
  output logic      [lcb_pkg::CH_W-1:0]      result
);

  localparam int PROD_W = 2 * lcb_pkg::OPND_W;
  localparam int P1_W   = lcb_pkg::CH_W + lcb_pkg::ALPHA_W;
  localparam int P2_W   = lcb_pkg::TGT_W + lcb_pkg::ALPHA_W + 1;
  localparam int SUM_W  = P2_W + 1;

  // stage 1: shared multiplier for multiply and screen
  logic signed [lcb_pkg::OPND_W-1:0] opnd_x;
  logic signed [lcb_pkg::OPND_W-1:0] opnd_y;
  logic [lcb_pkg::CH_W-1:0]          s1_a;
  logic [lcb_pkg::CH_W-1:0]          s1_b;
  logic signed [PROD_W-1:0]          s1_prod;

  // stage 2: target
  logic signed [PROD_W-1:0]          rounded;
  logic signed [lcb_pkg::TGT_W-1:0]  t_next;
  logic [lcb_pkg::CH_W-1:0]          s2_a;
  logic signed [lcb_pkg::TGT_W-1:0]  s2_t;

  // stage 3: weighted terms
  logic [lcb_pkg::ALPHA_W-1:0]       inv_alpha;
  logic [P1_W-1:0]                   s3_p1;
  logic signed [P2_W-1:0]            s3_p2;

  // stage 4: sum, floor, clamp
  logic signed [SUM_W-1:0]           sum;
  logic signed [SUM_W-1:0]           floored;
  logic [lcb_pkg::CH_W-1:0]          result_next;

  always_comb begin
    if (mode == lcb_pkg::MODE_SCREEN) begin
      opnd_x = lcb_pkg::OPND_W'(lcb_pkg::ONE_Q12) - $signed({2'b00, a});
      opnd_y = lcb_pkg::OPND_W'(lcb_pkg::ONE_Q12) - $signed({2'b00, b});
    end else begin
      opnd_x = $signed({2'b00, a});
      opnd_y = $signed({2'b00, b});
    end
  end

  always_ff @(posedge clk) begin
    s1_a    <= a;
    s1_b    <= b;
    s1_prod <= opnd_x * opnd_y;
  end

  always_comb begin
    rounded = (s1_prod + PROD_W'(lcb_pkg::HALF_Q12)) >>> lcb_pkg::FRAC_W;
    case (mode)
      lcb_pkg::MODE_ADD: begin
        t_next = $signed(lcb_pkg::TGT_W'(s1_a) + lcb_pkg::TGT_W'(s1_b));
      end
      lcb_pkg::MODE_MULTIPLY: begin
        t_next = rounded[lcb_pkg::TGT_W-1:0];
      end
      lcb_pkg::MODE_SCREEN: begin
        if (is_alpha) begin
          t_next = lcb_pkg::TGT_W'(lcb_pkg::ONE_Q12);
        end else begin
          t_next = lcb_pkg::TGT_W'(lcb_pkg::ONE_Q12) - rounded[lcb_pkg::TGT_W-1:0];
        end
      end
      lcb_pkg::MODE_MAX: begin
        if (is_alpha) begin
          t_next = lcb_pkg::TGT_W'(lcb_pkg::ONE_Q12);
        end else begin
          t_next = $signed(lcb_pkg::TGT_W'((s1_a > s1_b) ? s1_a : s1_b));
        end
      end
      lcb_pkg::MODE_MIN: begin
        if (is_alpha) begin
          t_next = lcb_pkg::TGT_W'(lcb_pkg::ONE_Q12);
        end else begin
          t_next = $signed(lcb_pkg::TGT_W'((s1_a < s1_b) ? s1_a : s1_b));
        end
      end
      default: begin
        // normal, and the unused codes
        t_next = $signed(lcb_pkg::TGT_W'(s1_b));
      end
    endcase
  end

  always_ff @(posedge clk) begin
    s2_a <= s1_a;
    s2_t <= t_next;
  end

  assign inv_alpha = lcb_pkg::ALPHA_W'(lcb_pkg::ONE_Q12) - alpha;

  always_ff @(posedge clk) begin
    s3_p1 <= P1_W'(s2_a) * P1_W'(inv_alpha);
    s3_p2 <= P2_W'(s2_t) * $signed({1'b0, alpha});
  end

  always_comb begin
    sum     = $signed({1'b0, s3_p1}) + SUM_W'(s3_p2) + SUM_W'(lcb_pkg::HALF_Q12);
    floored = sum >>> lcb_pkg::FRAC_W;
    if (floored < 0) begin
      result_next = '0;
    end else if (floored > SUM_W'(65535)) begin
      result_next = '1;
    end else begin
      result_next = floored[lcb_pkg::CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

`default_nettype wire

[hw/rtl/layer_color_blend.sv]
// Top level of the layer blend compositor: registers, lanes, merge.
//
//  channel   direction  transfer when                       payload
//  pixel     in         start && !busy at clk rise          pixel_in_t
//  result    out        done high for one cycle             pixel_out_t
//  config    in         psel && penable && pwrite (pready)  pwdata, paddr
//
// One pixel enters every cycle; busy stays low.
// The result follows the start transfer through a stage for the opacity/mask
// and target products, one for the target, one for the two lerp products and
// one for the sum and saturation.
// Reset clears the valid pipeline and the registers to normal mode,
// opacity 1.0 and mask off. The receiver cannot stall the result.
`timescale 1ns / 1ps
`default_nettype none
`include "layer_color_blend_macros.svh"

module layer_color_blend (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire lcb_pkg::pixel_in_t  pixel,
  output logic                     done,
  output lcb_pkg::pixel_out_t      result,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int DEPTH = 4;

  lcb_pkg::blend_mode_t            blend_mode;
  logic [lcb_pkg::CH_W-1:0]        layer_opacity;
  logic                            mask_enable;

  logic                            wr_en;
  logic [1:0]                      reg_idx;
  logic [DEPTH-1:0]                valid;
  logic [lcb_pkg::ALPHA_W-1:0]     alpha;

  logic [lcb_pkg::CH_W-1:0]        base_ch  [lcb_pkg::LANES];
  logic [lcb_pkg::CH_W-1:0]        layer_ch [lcb_pkg::LANES];
  logic [lcb_pkg::CH_W-1:0]        lane_out [lcb_pkg::LANES];

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode    <= lcb_pkg::MODE_NORMAL;
      layer_opacity <= lcb_pkg::CH_W'(lcb_pkg::ONE_Q12);
      mask_enable   <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        lcb_pkg::REG_BLEND_MODE:    blend_mode    <= lcb_pkg::blend_mode_t'(pwdata[2:0]);
        lcb_pkg::REG_LAYER_OPACITY: layer_opacity <= pwdata[lcb_pkg::CH_W-1:0];
        lcb_pkg::REG_MASK_ENABLE:   mask_enable   <= pwdata[0];
        default: begin
          // drop writes past the last register
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lcb_pkg::REG_BLEND_MODE:    prdata = {29'd0, blend_mode};
      lcb_pkg::REG_LAYER_OPACITY: prdata = {16'd0, layer_opacity};
      lcb_pkg::REG_MASK_ENABLE:   prdata = {31'd0, mask_enable};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[DEPTH-2:0], start && !busy};
    end
  end

  assign done = valid[DEPTH-1];

  assign base_ch[0]  = pixel.base_red;
  assign base_ch[1]  = pixel.base_green;
  assign base_ch[2]  = pixel.base_blue;
  assign base_ch[3]  = pixel.base_alpha;
  assign layer_ch[0] = pixel.layer_red;
  assign layer_ch[1] = pixel.layer_green;
  assign layer_ch[2] = pixel.layer_blue;
  assign layer_ch[3] = pixel.layer_alpha;

  lcb_alpha u_alpha (
    .clk         (clk),
    .opacity     (layer_opacity),
    .mask_enable (mask_enable),
    .mask_value  (pixel.mask_value),
    .alpha       (alpha)
  );

  for (genvar i = 0; i < lcb_pkg::LANES; i++) begin : g_lane
    lcb_lane u_lane (
      .clk      (clk),
      .a        (base_ch[i]),
      .b        (layer_ch[i]),
      .is_alpha (i == lcb_pkg::LANES - 1),
      .mode     (blend_mode),
      .alpha    (alpha),
      .result   (lane_out[i])
    );
  end

  // merge the lane results into one pixel
  assign result.out_red   = lane_out[0];
  assign result.out_green = lane_out[1];
  assign result.out_blue  = lane_out[2];
  assign result.out_alpha = lane_out[3];

  `LCB_ASSERT_IMPL(a_done_after_start, clk, rst, done, $past(start, 4))
  `LCB_ASSERT_IMPL(a_alpha_clamped, clk, rst, 1'b1, alpha <= lcb_pkg::ALPHA_W'(lcb_pkg::ONE_Q12))
  `LCB_ASSERT_NEXT(a_opacity_written, clk, rst, wr_en && reg_idx == lcb_pkg::REG_LAYER_OPACITY, layer_opacity == $past(pwdata[15:0]))

endmodule

`default_nettype wire
